// ===== sv/hlm_pkg.sv =====
// ----------------------------------------------------------------------------
// hlm_pkg: shared types, constants and DES helper functions
// Permutations, S-boxes and the round function used by the round pipeline.
// ----------------------------------------------------------------------------
package hlm_pkg;

  localparam int PW_W    = 56;
  localparam int BLK_W   = 64;
  localparam int ROUNDS  = 16;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_CHALLENGE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET    = 1'd1;

  localparam logic [BLK_W-1:0] MAGIC_BLOCK = 64'h4B47532140232425;

  typedef logic [BLK_W-1:0] blk_t;
  typedef logic [PW_W-1:0]  key56_t;

  // one round stage: key halves and data halves
  typedef struct packed {
    logic [27:0] c;
    logic [27:0] d;
    logic [31:0] l;
    logic [31:0] r;
  } rnd_t;

  localparam logic [7:0] TAB_IP [64] = '{58,50,42,34,26,18,10,2,60,52,44,36,28,20,12,4,
    62,54,46,38,30,22,14,6,64,56,48,40,32,24,16,8,57,49,41,33,25,17,9,1,59,51,43,35,27,19,
    11,3,61,53,45,37,29,21,13,5,63,55,47,39,31,23,15,7};
  localparam logic [7:0] TAB_FP [64] = '{40,8,48,16,56,24,64,32,39,7,47,15,55,23,63,31,
    38,6,46,14,54,22,62,30,37,5,45,13,53,21,61,29,36,4,44,12,52,20,60,28,35,3,43,11,51,
    19,59,27,34,2,42,10,50,18,58,26,33,1,41,9,49,17,57,25};
  localparam logic [7:0] TAB_E [48] = '{32,1,2,3,4,5,4,5,6,7,8,9,8,9,10,11,12,13,12,13,
    14,15,16,17,16,17,18,19,20,21,20,21,22,23,24,25,24,25,26,27,28,29,28,29,30,31,32,1};
  localparam logic [7:0] TAB_P [32] = '{16,7,20,21,29,12,28,17,1,15,23,26,5,18,31,10,2,
    8,24,14,32,27,3,9,19,13,30,6,22,11,4,25};
  localparam logic [7:0] TAB_PC1 [56] = '{57,49,41,33,25,17,9,1,58,50,42,34,26,18,10,2,
    59,51,43,35,27,19,11,3,60,52,44,36,63,55,47,39,31,23,15,7,62,54,46,38,30,22,14,6,61,
    53,45,37,29,21,13,5,28,20,12,4};
  localparam logic [7:0] TAB_PC2 [48] = '{14,17,11,24,1,5,3,28,15,6,21,10,23,19,12,4,26,
    8,16,7,27,20,13,2,41,52,31,37,47,55,30,40,51,45,33,48,44,49,39,56,34,53,46,42,50,36,
    29,32};
  localparam logic [1:0] TAB_SHIFT [16] = '{1,1,2,2,2,2,2,2,1,2,2,2,2,2,2,1};
  localparam logic [3:0] TAB_S [8][64] = '{
    '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7,0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
      4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0,15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
    '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10,3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
      0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15,13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
    '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8,13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
      13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7,1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
    '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15,13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
      10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4,3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
    '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9,14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
      4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14,11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
    '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11,10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
      9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6,4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
    '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1,13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
      1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2,6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
    '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7,1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
      7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8,2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};

  // upper-case letters up to the first zero byte, clear everything after it
  function automatic key56_t normalize(input key56_t pw);
    key56_t o;
    logic   ended;
    logic [7:0] b;
    o = '0;
    ended = 1'b0;
    for (int i = 0; i < 7; i++) begin
      b = pw[PW_W-1-8*i -: 8];
      if (ended) b = 8'h00;
      else if (b == 8'h00) ended = 1'b1;
      else if (b >= 8'h61 && b <= 8'h7A) b = b ^ 8'h20;
      o[PW_W-1-8*i -: 8] = b;
    end
    return o;
  endfunction

  // PC-1 on the parity-spread key, taken straight from the 56 key bits
  function automatic logic [55:0] pc1(input key56_t k);
    logic [63:0] s;
    logic [55:0] o;
    for (int i = 0; i < 8; i++) s[63-8*i -: 8] = {k[55-7*i -: 7], 1'b0};
    for (int i = 0; i < 56; i++) o[55-i] = s[64-int'(TAB_PC1[i])];
    return o;
  endfunction

  function automatic blk_t ip(input blk_t v);
    blk_t o;
    for (int i = 0; i < 64; i++) o[63-i] = v[64-int'(TAB_IP[i])];
    return o;
  endfunction

  function automatic blk_t fp(input blk_t v);
    blk_t o;
    for (int i = 0; i < 64; i++) o[63-i] = v[64-int'(TAB_FP[i])];
    return o;
  endfunction

  function automatic logic [27:0] rotl(input logic [27:0] v, input logic [1:0] s);
    return (s == 2'd1) ? {v[26:0], v[27]} : {v[25:0], v[27:26]};
  endfunction

  function automatic logic [31:0] feistel(input logic [31:0] r, input logic [55:0] cd);
    logic [47:0] x;
    logic [31:0] f;
    logic [31:0] o;
    logic [5:0]  b;
    for (int i = 0; i < 48; i++)
      x[47-i] = r[32-int'(TAB_E[i])] ^ cd[56-int'(TAB_PC2[i])];
    for (int j = 0; j < 8; j++) begin
      b = x[47-6*j -: 6];
      f[31-4*j -: 4] = TAB_S[j][{b[5], b[0], b[4:1]}];
    end
    for (int i = 0; i < 32; i++) o[31-i] = f[32-int'(TAB_P[i])];
    return o;
  endfunction

endpackage

// ===== sv/hlm_if.sv =====
// ----------------------------------------------------------------------------
// hlm_if: valid/ready channel
// Carries one payload of parameterized type between a source and a sink.
// ----------------------------------------------------------------------------
interface hlm_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/hlm_round.sv =====
// ----------------------------------------------------------------------------
// hlm_round: one registered DES round
// Rotates the key halves, applies the round function, holds on stall.
// ----------------------------------------------------------------------------
module hlm_round #(
  parameter int ROUND = 0
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           adv,
  input  logic           vld_in,
  input  hlm_pkg::rnd_t  st_in,
  input  hlm_pkg::blk_t  aux_in,
  output logic           vld_out,
  output hlm_pkg::rnd_t  st_out,
  output hlm_pkg::blk_t  aux_out
);
  import hlm_pkg::*;

  logic  vld_r;
  rnd_t  st_r, st_nxt;
  blk_t  aux_r;

  always_comb begin
    st_nxt.c = rotl(st_in.c, TAB_SHIFT[ROUND]);
    st_nxt.d = rotl(st_in.d, TAB_SHIFT[ROUND]);
    st_nxt.l = st_in.r;
    st_nxt.r = st_in.l ^ feistel(st_in.r, {st_nxt.c, st_nxt.d});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st_r  <= st_nxt;
      aux_r <= aux_in;
    end
  end

  assign vld_out = vld_r;
  assign st_out  = st_r;
  assign aux_out = aux_r;
endmodule

// ===== sv/hlm_des_pipe.sv =====
// ----------------------------------------------------------------------------
// hlm_des_pipe: sixteen-stage DES encryption pipeline
// Loads key and block, runs one round per stage, applies the final permutation.
// ----------------------------------------------------------------------------
module hlm_des_pipe (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           adv,
  input  logic           vld_in,
  input  hlm_pkg::key56_t key_in,
  input  hlm_pkg::blk_t  blk_in,
  input  hlm_pkg::blk_t  aux_in,
  output logic           vld_out,
  output hlm_pkg::blk_t  blk_out,
  output hlm_pkg::blk_t  aux_out
);
  import hlm_pkg::*;

  logic  vld [ROUNDS+1];
  rnd_t  st  [ROUNDS+1];
  blk_t  aux [ROUNDS+1];
  logic [55:0] cd;
  blk_t  lr;

  assign cd = pc1(key_in);
  assign lr = ip(blk_in);
  assign vld[0] = vld_in;
  assign st[0]  = '{c: cd[55:28], d: cd[27:0], l: lr[63:32], r: lr[31:0]};
  assign aux[0] = aux_in;

  for (genvar g = 0; g < ROUNDS; g++) begin : g_rnd
    hlm_round #(.ROUND(g)) u_rnd (
      .clk, .rst_n, .adv,
      .vld_in (vld[g]),   .st_in (st[g]),   .aux_in (aux[g]),
      .vld_out(vld[g+1]), .st_out(st[g+1]), .aux_out(aux[g+1])
    );
  end

  assign vld_out = vld[ROUNDS];
  assign blk_out = fp({st[ROUNDS].r, st[ROUNDS].l});
  assign aux_out = aux[ROUNDS];
endmodule

// ===== sv/halflm_response_check.sv =====
// ----------------------------------------------------------------------------
// halflm_response_check: half-LM DES challenge-response checker
// Normalizes a password, derives the LM half key, answers the challenge.
// ----------------------------------------------------------------------------
// Accepts one password item per cycle while the output register is not
// stalled. An accepted item passes through an input register, two chained
// sixteen-round DES pipelines, one round per stage, and an output register
// that holds the result. The whole chain advances together whenever the
// output register is empty or being taken, so a stall holds every stage in
// place. The challenge and target registers are sampled at the second DES
// stage and at the output, and must only be written while no item is in flight.
module halflm_response_check (
  input  logic clk,
  input  logic rst_n,
  hlm_if.sink   in_ch,
  hlm_if.source out_ch,
  input  logic                          cfg_we,
  input  logic [hlm_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [hlm_pkg::BLK_W-1:0]     cfg_wdata
);
  import hlm_pkg::*;

  typedef struct packed {
    blk_t response_block;
    logic is_match;
  } res_t;

  blk_t   chal_r, tgt_r;
  logic   adv;
  logic   in_vld_r;
  key56_t in_pw_r;
  logic   v1, v2;
  blk_t   lm, resp, aux1, aux2;
  logic   out_vld_r;
  res_t   out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chal_r <= '0;
      tgt_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_CHALLENGE: chal_r <= cfg_wdata;
        REG_TARGET:    tgt_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // one enable for the whole chain
  assign adv = !out_vld_r || out_ch.ready;
  assign in_ch.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (adv) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) in_pw_r <= normalize(in_ch.data);
  end

  hlm_des_pipe u_lm (
    .clk, .rst_n, .adv,
    .vld_in(in_vld_r), .key_in(in_pw_r), .blk_in(MAGIC_BLOCK), .aux_in('0),
    .vld_out(v1), .blk_out(lm), .aux_out(aux1)
  );

  hlm_des_pipe u_resp (
    .clk, .rst_n, .adv,
    .vld_in(v1), .key_in(lm[63:8]), .blk_in(chal_r), .aux_in(aux1),
    .vld_out(v2), .blk_out(resp), .aux_out(aux2)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r.response_block <= resp ^ aux2;
      out_r.is_match       <= ((resp ^ aux2) == tgt_r);
    end
  end

  assign out_ch.valid = out_vld_r;
  assign out_ch.data  = out_r;

`ifndef SYNTH
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> $stable(out_ch.data))
    else $error("result changed under stall");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_ch.valid |-> in_ch.ready)
    else $error("input stalled with empty output");
  a_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_r.is_match == (out_r.response_block == tgt_r)))
    else $error("match flag inconsistent");
`endif
endmodule
